### src/decaying_multitap_ring_delay_core_macros.svh
// Assertion macros for the multitap ring delay core.
// Included by the top level; no other dependencies.
`ifndef DECAYING_MULTITAP_RING_DELAY_CORE_MACROS_SVH
`define DECAYING_MULTITAP_RING_DELAY_CORE_MACROS_SVH
`ifndef SYNTH
`define DMRD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DMRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DMRD_ASSERT_IMPL(label, ante, cons)
`define DMRD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/dmrd_pkg.sv
// Package for the multitap ring delay: constants, payload structs, FSM codes.
// No dependencies.
package dmrd_pkg;
  localparam int DelayDepth  = 32768;
  localparam int OutChannels = 8;
  localparam int AW = $clog2(DelayDepth);
  localparam int LW = AW + 1;
  localparam int CW = (OutChannels > 1) ? $clog2(OutChannels) : 1;
  localparam int LenMin = 500;
  localparam logic [15:0] FadeReset = 16'd64881;
  localparam logic [15:0] LenReset  = 16'd32768;
  localparam logic [6:0]  NeighGain = 7'd66;
  localparam logic signed [23:0] StoreMax = 24'sh7FFFFF;
  localparam logic signed [23:0] StoreMin = -24'sh800000;

  typedef enum logic [1:0] {
    CMD_DECAY = 2'd0,
    CMD_MIC   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic CFG_FADE = 1'b0;
  localparam logic CFG_LEN  = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] mic_a;
    logic signed [15:0] mic_b;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [23:0] sample_out;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_POS, ST_GROW,
    ST_DEC_RD, ST_DEC_MUL, ST_DEC_WR,
    ST_MA_RD, ST_MA_WR, ST_MB_RD, ST_MB_WR,
    ST_RD_RD, ST_RD_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    state_t st;
    logic   ld_item;
    logic   out_take;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic at_end;   // index reached its bound
    logic out_full;
  } dp_stat_t;

  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    if (v > 50'(StoreMax)) return StoreMax;
    else if (v < 50'(StoreMin)) return StoreMin;
    else return v[23:0];
  endfunction
endpackage

### src/decaying_multitap_ring_delay_core.sv
// Decaying multitap ring delay. After reset a clearing pass zeroes the store;
// no item is taken meanwhile. A read frame reads and outputs each channel's
// tap; a mic frame reads and writes each mic position; a decay pass reads,
// multiplies and writes each active entry through one store port. Length
// writes clear newly exposed entries one a cycle, then reset the taps.
module decaying_multitap_ring_delay_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dmrd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dmrd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import dmrd_pkg::*;
  `include "decaying_multitap_ring_delay_core_macros.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;
  in_item_t item;

  // hold the item for the mic frame
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) item <= in_data;
  end

  assign cfg_ready = (cmd.st == ST_IDLE);

  dmrd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_cmd(in_data.command),
    .cfg_len_wr(cfg_valid && cfg_index == CFG_LEN),
    .stat, .out_stall, .cmd
  );

  dmrd_datapath u_dp (
    .clk, .rst, .cmd, .in_item(item), .cfg_valid,
    .cfg_index(cfg_index[0]), .cfg_data, .out_stall,
    .out_item(out_data), .out_valid, .stat
  );

  `DMRD_ASSERT_IMPL(a_no_take_busy, !in_stall, cmd.st == ST_IDLE)
  `DMRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `DMRD_ASSERT_IMPL(a_last_chan, out_valid && out_data.last,
                    out_data.channel == 3'(OutChannels - 1))
endmodule

### src/dmrd_ctrl.sv
// Controller state machine of the multitap ring delay.
// Uses dmrd_pkg; drives the datapath through dp_cmd_t.
module dmrd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic               cfg_len_wr,
  input  dmrd_pkg::dp_stat_t stat,
  input  logic               out_stall,
  output dmrd_pkg::dp_cmd_t  cmd
);
  import dmrd_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    cmd.st       = state;
    cmd.ld_item  = 1'b0;
    cmd.out_take = 1'b0;
    unique case (state)
      ST_CLEAR:   if (stat.at_end) state_next = ST_IDLE;
      ST_IDLE: begin
        if (cfg_len_wr) state_next = ST_GROW;
        else begin
          in_stall = 1'b0;
          if (in_valid) begin
            cmd.ld_item = 1'b1;
            priority case (in_cmd)
              CMD_DECAY: state_next = ST_DEC_RD;
              CMD_MIC:   state_next = ST_MA_RD;
              CMD_READ:  state_next = ST_RD_RD;
              default:   state_next = ST_IDLE;
            endcase
          end
        end
      end
      ST_GROW:    if (stat.at_end) state_next = ST_POS;
      ST_POS:     if (stat.at_end) state_next = ST_IDLE;
      ST_DEC_RD:  state_next = ST_DEC_MUL;
      ST_DEC_MUL: state_next = ST_DEC_WR;
      ST_DEC_WR:  state_next = stat.at_end ? ST_IDLE : ST_DEC_RD;
      ST_MA_RD:   state_next = ST_MA_WR;
      ST_MA_WR:   state_next = ST_MB_RD;
      ST_MB_RD:   state_next = ST_MB_WR;
      ST_MB_WR:   state_next = ST_IDLE;
      ST_RD_RD:   state_next = ST_RD_OUT;
      ST_RD_OUT: begin
        if (!stat.out_full || !out_stall) begin
          cmd.out_take = 1'b1;
          state_next = stat.at_end ? ST_IDLE : ST_RD_RD;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end
endmodule

### src/dmrd_datapath.sv
// Datapath: ring store, positions, decay arithmetic, output register.
// Uses dmrd_pkg; sequenced by dmrd_ctrl.
module dmrd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  dmrd_pkg::dp_cmd_t   cmd,
  input  dmrd_pkg::in_item_t  in_item,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                out_stall,
  output dmrd_pkg::out_item_t out_item,
  output logic                out_valid,
  output dmrd_pkg::dp_stat_t  stat
);
  import dmrd_pkg::*;

  logic signed [23:0] mem [DelayDepth];
  logic signed [23:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic signed [23:0] wdata;

  logic [15:0]   fade_gain;
  logic [LW-1:0] len;
  logic [AW-1:0] pos_a, pos_b;
  logic [AW-1:0] taps [OutChannels];
  logic [LW-1:0] idx;
  logic [CW-1:0] ch;
  logic signed [23:0] prev;
  logic signed [39:0] prod_d;
  logic signed [31:0] prod_n;
  logic [LW+CW-1:0] tap_acc;

  // clamp of requested length
  logic [LW-1:0] len_req;
  always_comb begin
    if (cfg_data < 16'(LenMin)) len_req = LW'(LenMin);
    else if (32'(cfg_data) > 32'(DelayDepth)) len_req = LW'(DelayDepth);
    else len_req = LW'(cfg_data);
  end

  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] p,
                                             input logic [LW-1:0] l);
    logic [LW-1:0] n;
    n = LW'(p) + LW'(1);
    return (n >= l) ? AW'(0) : n[AW-1:0];
  endfunction

  // store read address and write port
  always_comb begin
    raddr = idx[AW-1:0];
    we = 1'b0; waddr = idx[AW-1:0]; wdata = '0;
    unique case (cmd.st)
      ST_CLEAR:  begin we = 1'b1; end
      ST_GROW:   begin we = !stat.at_end; end
      ST_DEC_WR: begin
        we = 1'b1;
        wdata = sat24(50'($signed(prod_d[39:16])) + 50'($signed(prod_n[31:16])));
      end
      ST_MA_RD, ST_MA_WR: begin
        raddr = pos_a; waddr = pos_a;
        we = (cmd.st == ST_MA_WR);
        wdata = sat24(50'(rdata) + 50'(in_item.mic_a) + 50'(in_item.mic_a));
      end
      ST_MB_RD, ST_MB_WR: begin
        raddr = pos_b; waddr = pos_b;
        we = (cmd.st == ST_MB_WR);
        wdata = sat24(50'(rdata) + 50'(in_item.mic_b) + 50'(in_item.mic_b));
      end
      ST_RD_RD, ST_RD_OUT: raddr = taps[ch];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // end-of-walk status
  always_comb begin
    unique case (cmd.st)
      ST_CLEAR:  stat.at_end = (idx == LW'(DelayDepth - 1));
      ST_GROW:   stat.at_end = (idx >= len);
      ST_POS:    stat.at_end = (ch == CW'(OutChannels - 1)) || (OutChannels == 1);
      ST_DEC_WR: stat.at_end = (idx == len - LW'(1));
      ST_RD_OUT: stat.at_end = (ch == CW'(OutChannels - 1)) || (OutChannels == 1);
      default:   stat.at_end = 1'b0;
    endcase
  end
  assign stat.out_full = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_gain <= FadeReset;
      len <= LW'(DelayDepth);
      pos_a <= '0;
      pos_b <= AW'(DelayDepth / 2);
      for (int j = 0; j < OutChannels; j++)
        taps[j] <= AW'((DelayDepth * j) / OutChannels);
      idx <= '0; ch <= '0; tap_acc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !cmd.out_take) out_valid <= 1'b0;
      if (cfg_valid && cmd.st == ST_IDLE) begin
        if (cfg_index == CFG_FADE) fade_gain <= cfg_data;
        else begin
          len <= len_req;
          idx <= len; ch <= '0; tap_acc <= '0;
        end
      end
      if (cmd.ld_item) begin
        idx <= '0; ch <= '0; prev <= '0;
      end
      unique case (cmd.st)
        ST_CLEAR: idx <= idx + LW'(1);
        ST_GROW: if (!stat.at_end) idx <= idx + LW'(1);
        ST_POS: begin
          // floor(len*j/OutChannels) by running sum
          taps[ch] <= AW'(tap_acc / OutChannels);
          tap_acc <= tap_acc + (LW+CW)'(len);
          ch <= ch + CW'(1);
          if (stat.at_end) begin
            pos_a <= '0;
            pos_b <= AW'(len >> 1);
          end
        end
        ST_DEC_MUL: begin
          prod_d <= $signed(rdata) * $signed({1'b0, fade_gain}) + 40'sd32768;
          prod_n <= prev * $signed({1'b0, NeighGain}) + 32'sd32768;
        end
        ST_DEC_WR: begin
          prev <= wdata;
          idx <= idx + LW'(1);
        end
        ST_MA_WR: pos_a <= inc_wrap(pos_a, len);
        ST_MB_WR: pos_b <= inc_wrap(pos_b, len);
        ST_RD_OUT: if (cmd.out_take) begin
          out_item.channel <= 3'(ch);
          out_item.sample_out <= rdata;
          out_item.last <= stat.at_end;
          out_valid <= 1'b1;
          taps[ch] <= inc_wrap(taps[ch], len);
          ch <= ch + CW'(1);
        end
        default: ;
      endcase
    end
  end
endmodule
